>>> hw/rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Types, sizes and codes shared by the first-fit hole allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned LIVE_ENTRIES = 16;
  localparam int unsigned HOLE_ENTRIES = 16;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned SIZE_W = 8;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned STAT_W = 3;

  localparam int unsigned LIVE_IDX_W = $clog2(LIVE_ENTRIES);
  localparam int unsigned HOLE_IDX_W = $clog2(HOLE_ENTRIES);
  localparam int unsigned LCNT_W     = $clog2(LIVE_ENTRIES + 1);
  localparam int unsigned HCNT_W     = $clog2(HOLE_ENTRIES + 1);
  localparam int unsigned WALK_W     = ((LCNT_W > HCNT_W) ? LCNT_W : HCNT_W) + 1;

  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = ADDR_W'(20000);

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_NO_SPACE     = 3'd1,
    ST_TABLE_FULL   = 3'd2,
    ST_ID_NOT_FOUND = 3'd3,
    ST_HOLE_DROPPED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HSRCH,
    S_HSHIFT,
    S_LSRCH,
    S_LSHIFT,
    S_DONE
  } state_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } hole_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } live_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] block_address;
    logic [ID_W-1:0]   block_id;
    logic              reused_hole;
  } rsp_t;

endpackage

>>> hw/rtl/ffha_if.sv
// ----------------------------------------------------------------------------
// ffha_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface ffha_req_if
  import ffha_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [SIZE_W-1:0] request_size;
  logic [ID_W-1:0]   free_id;

  modport source (output valid, operation, request_size, free_id, input ready);
  modport sink   (input valid, operation, request_size, free_id, output ready);
endinterface

interface ffha_rsp_if
  import ffha_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] block_address;
  logic [ID_W-1:0]   block_id;
  logic              reused_hole;

  modport source (output valid, status, block_address, block_id, reused_hole,
                  input ready);
  modport sink   (input valid, status, block_address, block_id, reused_hole,
                  output ready);
endinterface

>>> hw/rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/first_fit_hole_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_hole_allocator_top
// First-fit heap allocator with bump pointer, hole list and allocation table.
// ----------------------------------------------------------------------------
// Requests arrive on req_i (operation, request_size, free_id); one result beat
// per request leaves on rsp_o (status, block_address, block_id, reused_hole).
// cfg_we_i/cfg_data_i write heap_limit; the user must write it only while the
// block is idle, since the block itself does not enforce this. One request is
// worked at a time by a sequencer that walks the hole list or the allocation
// table one entry per cycle through a registered RAM read. Allocate takes the
// first hole that fits, shifting the later holes down, or else bumps the
// pointer; free finds the id, shifts later table entries down and adds a hole.
// req_i.ready is high only between requests. A finished result sits in an
// output register; the next request is taken while it waits, but its own
// result is held back until rsp_o accepts the older beat.
// Reset: heap_limit 20000, bump pointer 0, next id 1, both lists empty.
// ----------------------------------------------------------------------------
module first_fit_hole_allocator_top
  import ffha_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_data_i,
  ffha_req_if.sink          req_i,
  ffha_rsp_if.source        rsp_o
);

  state_e              state_q, state_d;
  logic [WALK_W-1:0]   idx_q, idx_d;
  logic [LCNT_W-1:0]   lcnt_q, lcnt_d;
  logic [HCNT_W-1:0]   hcnt_q, hcnt_d;
  logic [ADDR_W-1:0]   bump_q, bump_d;
  logic [ID_W-1:0]     nid_q, nid_d;
  logic [ADDR_W-1:0]   limit_q;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [ID_W-1:0]     id_q, id_d;
  logic [ADDR_W-1:0]   faddr_q, faddr_d;
  logic [SIZE_W-1:0]   fsize_q, fsize_d;
  rsp_t                res_q, res_d;
  rsp_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                hole_we, live_we;
  logic [HOLE_IDX_W-1:0] hole_waddr;
  logic [LIVE_IDX_W-1:0] live_waddr;
  hole_t               hole_wdata, hole_rd;
  live_t               live_wdata, live_rd;

  logic                try_bump, commit, free_fin;
  logic [ADDR_W-1:0]   c_addr;
  logic [SIZE_W-1:0]   c_size;
  logic                c_reused;
  logic [SIZE_W-1:0]   cur_size;
  logic [ADDR_W:0]     bump_sum;
  logic [WALK_W-1:0]   idx_nx;
  logic [WALK_W-1:0]   hcnt_w, lcnt_w;
  logic                accept;

  assign accept   = req_i.valid && req_i.ready;
  assign cur_size = (state_q == S_IDLE) ? req_i.request_size : size_q;
  assign bump_sum = {1'b0, bump_q} + {{(ADDR_W+1-SIZE_W){1'b0}}, cur_size};
  assign idx_nx   = idx_q + WALK_W'(1);
  assign hcnt_w   = WALK_W'(hcnt_q);
  assign lcnt_w   = WALK_W'(lcnt_q);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    lcnt_d      = lcnt_q;
    hcnt_d      = hcnt_q;
    bump_d      = bump_q;
    nid_d       = nid_q;
    size_d      = size_q;
    id_d        = id_q;
    faddr_d     = faddr_q;
    fsize_d     = fsize_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    req_i.ready = 1'b0;
    hole_we     = 1'b0;
    live_we     = 1'b0;
    hole_waddr  = idx_q[HOLE_IDX_W-1:0] - HOLE_IDX_W'(1);
    live_waddr  = idx_q[LIVE_IDX_W-1:0] - LIVE_IDX_W'(1);
    hole_wdata  = hole_rd;
    live_wdata  = live_rd;
    try_bump    = 1'b0;
    commit      = 1'b0;
    free_fin    = 1'b0;
    c_addr      = faddr_q;
    c_size      = fsize_q;
    c_reused    = 1'b1;

    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (accept) begin
          idx_d  = '0;
          size_d = req_i.request_size;
          id_d   = req_i.free_id;
          if (req_i.operation == OP_ALLOC) begin
            if (lcnt_q == LCNT_W'(LIVE_ENTRIES)) begin
              res_d   = '{ST_TABLE_FULL, '0, '0, 1'b0};
              state_d = S_DONE;
            end else if (hcnt_q != '0) begin
              state_d = S_HSRCH;
            end else begin
              try_bump = 1'b1;
            end
          end else begin
            if (lcnt_q == '0) begin
              res_d   = '{ST_ID_NOT_FOUND, '0, req_i.free_id, 1'b0};
              state_d = S_DONE;
            end else begin
              state_d = S_LSRCH;
            end
          end
        end
      end
      S_HSRCH: begin
        if (hole_rd.size >= size_q) begin
          faddr_d = hole_rd.addr;
          fsize_d = hole_rd.size;
          if (idx_nx < hcnt_w) begin
            idx_d   = idx_nx;
            state_d = S_HSHIFT;
          end else begin
            hcnt_d = hcnt_q - HCNT_W'(1);
            commit = 1'b1;
            c_addr = hole_rd.addr;
            c_size = hole_rd.size;
          end
        end else if (idx_nx < hcnt_w) begin
          idx_d = idx_nx;
        end else begin
          try_bump = 1'b1;
        end
      end
      S_HSHIFT: begin
        hole_we = 1'b1;
        if (idx_nx < hcnt_w) begin
          idx_d = idx_nx;
        end else begin
          hcnt_d = hcnt_q - HCNT_W'(1);
          commit = 1'b1;
        end
      end
      S_LSRCH: begin
        if (live_rd.id == id_q) begin
          faddr_d = live_rd.addr;
          fsize_d = live_rd.size;
          if (idx_nx < lcnt_w) begin
            idx_d   = idx_nx;
            state_d = S_LSHIFT;
          end else begin
            lcnt_d   = lcnt_q - LCNT_W'(1);
            free_fin = 1'b1;
            c_addr   = live_rd.addr;
            c_size   = live_rd.size;
          end
        end else if (idx_nx < lcnt_w) begin
          idx_d = idx_nx;
        end else begin
          res_d   = '{ST_ID_NOT_FOUND, '0, id_q, 1'b0};
          state_d = S_DONE;
        end
      end
      S_LSHIFT: begin
        live_we = 1'b1;
        if (idx_nx < lcnt_w) begin
          idx_d = idx_nx;
        end else begin
          lcnt_d   = lcnt_q - LCNT_W'(1);
          free_fin = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (try_bump) begin
      state_d = S_DONE;
      if (bump_sum <= {1'b0, limit_q}) begin
        commit   = 1'b1;
        c_addr   = bump_q;
        c_size   = cur_size;
        c_reused = 1'b0;
        bump_d   = bump_sum[ADDR_W-1:0];
      end else begin
        res_d = '{ST_NO_SPACE, '0, '0, 1'b0};
      end
    end

    if (commit) begin
      live_we    = 1'b1;
      live_waddr = lcnt_q[LIVE_IDX_W-1:0];
      live_wdata = '{nid_q, c_addr, c_size};
      lcnt_d     = lcnt_q + LCNT_W'(1);
      nid_d      = nid_q + ID_W'(1);
      res_d      = '{ST_OK, c_addr, nid_q, c_reused};
      state_d    = S_DONE;
    end

    if (free_fin) begin
      state_d = S_DONE;
      if (hcnt_q == HCNT_W'(HOLE_ENTRIES)) begin
        res_d = '{ST_HOLE_DROPPED, c_addr, id_q, 1'b0};
      end else begin
        hole_we    = 1'b1;
        hole_waddr = hcnt_q[HOLE_IDX_W-1:0];
        hole_wdata = '{c_addr, c_size};
        hcnt_d     = hcnt_q + HCNT_W'(1);
        res_d      = '{ST_OK, c_addr, id_q, 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      lcnt_q      <= '0;
      hcnt_q      <= '0;
      bump_q      <= '0;
      nid_q       <= ID_W'(1);
      limit_q     <= HEAP_LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      lcnt_q      <= lcnt_d;
      hcnt_q      <= hcnt_d;
      bump_q      <= bump_d;
      nid_q       <= nid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    size_q  <= size_d;
    id_q    <= id_d;
    faddr_q <= faddr_d;
    fsize_q <= fsize_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  ffha_ram #(
    .DEPTH (HOLE_ENTRIES),
    .WIDTH ($bits(hole_t))
  ) u_hole_ram (
    .clk_i   (clk_i),
    .we_i    (hole_we),
    .waddr_i (hole_waddr),
    .wdata_i (hole_wdata),
    .raddr_i (idx_d[HOLE_IDX_W-1:0]),
    .rdata_o (hole_rd)
  );

  ffha_ram #(
    .DEPTH (LIVE_ENTRIES),
    .WIDTH ($bits(live_t))
  ) u_live_ram (
    .clk_i   (clk_i),
    .we_i    (live_we),
    .waddr_i (live_waddr),
    .wdata_i (live_wdata),
    .raddr_i (idx_d[LIVE_IDX_W-1:0]),
    .rdata_o (live_rd)
  );

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_q.status;
  assign rsp_o.block_address = out_q.block_address;
  assign rsp_o.block_id      = out_q.block_id;
  assign rsp_o.reused_hole   = out_q.reused_hole;

endmodule

>>> hw/rtl/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffha_checker
  import ffha_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [STAT_W-1:0] status_i,
  input logic [ADDR_W-1:0] block_address_i,
  input logic [ID_W-1:0]   block_id_i,
  input logic              reused_hole_i
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(status_i) && $stable(block_address_i) &&
      $stable(block_id_i) && $stable(reused_hole_i))
    else $error("result beat changed while stalled");

  // one request in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != ST_OK |-> !reused_hole_i)
    else $error("hole reuse flagged on failed request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_ID_NOT_FOUND || status_i == ST_NO_SPACE ||
                    status_i == ST_TABLE_FULL) |-> block_address_i == '0)
    else $error("failed request carries an address");

endmodule

bind first_fit_hole_allocator_top ffha_checker u_ffha_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .status_i        (rsp_o.status),
  .block_address_i (rsp_o.block_address),
  .block_id_i      (rsp_o.block_id),
  .reused_hole_i   (rsp_o.reused_hole)
);

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit hole allocator.
// ----------------------------------------------------------------------------
// Drives a table of directed requests, then randomized fill, drain and mixed
// sequences under several heap limits. A behavioral model of the bump pointer,
// allocation table and hole list predicts each result beat but those of scripted
// rows with their own expected beat; every beat is checked field by field in
// order. Both channels idle and stall at random.
module tb
  import ffha_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TIMEOUT_NS  = 10_000_000;
  localparam int     IDLE_GUARD  = 40;
  localparam int     LONG_HOLD   = 400;
  localparam int     QUIET_FROM  = 640;
  localparam int     END_TARGET  = 720;

  typedef enum logic [2:0] {
    K_ALLOC,
    K_FREE,
    K_FREE_OLDEST,
    K_FREE_NEWEST,
    K_LIMIT
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] arg;
    logic [15:0] noise;
    logic        typed;
    rsp_t        want;
  } row_t;

  localparam rsp_t ANY = '{ST_OK, 16'd0, 16'd0, 1'b0};

  localparam row_t SCRIPT [21] = '{
    '{K_ALLOC,       16'd255,   16'h0000, 1'b1, '{ST_OK, 16'd0, 16'd1, 1'b0}},
    '{K_ALLOC,       16'd0,     16'hFFFF, 1'b0, ANY},
    '{K_ALLOC,       16'd1,     16'h0000, 1'b0, ANY},
    '{K_FREE,        16'd0,     16'h0000, 1'b1, '{ST_ID_NOT_FOUND, 16'd0, 16'd0, 1'b0}},
    '{K_FREE,        16'hFFFF,  16'h00FF, 1'b1, '{ST_ID_NOT_FOUND, 16'd0, 16'hFFFF, 1'b0}},
    '{K_FREE,        16'd2,     16'h0000, 1'b0, ANY},
    '{K_ALLOC,       16'd0,     16'h5555, 1'b0, ANY},
    '{K_FREE_OLDEST, 16'd0,     16'h00AA, 1'b0, ANY},
    '{K_ALLOC,       16'd200,   16'h0000, 1'b0, ANY},
    '{K_ALLOC,       16'd255,   16'hAAAA, 1'b0, ANY},
    '{K_FREE_NEWEST, 16'd0,     16'h0055, 1'b0, ANY},
    '{K_FREE_NEWEST, 16'd0,     16'h00FF, 1'b0, ANY},
    '{K_LIMIT,       16'd1,     16'h0000, 1'b0, ANY},
    '{K_ALLOC,       16'd255,   16'h0000, 1'b0, ANY},
    '{K_ALLOC,       16'd255,   16'hFFFF, 1'b0, ANY},
    '{K_ALLOC,       16'd1,     16'h0000, 1'b1, '{ST_NO_SPACE, 16'd0, 16'd0, 1'b0}},
    '{K_ALLOC,       16'd0,     16'h0000, 1'b1, '{ST_NO_SPACE, 16'd0, 16'd0, 1'b0}},
    '{K_LIMIT,       16'hFFFF,  16'h0000, 1'b0, ANY},
    '{K_ALLOC,       16'd128,   16'h1234, 1'b0, ANY},
    '{K_FREE_NEWEST, 16'd0,     16'h0080, 1'b0, ANY},
    '{K_FREE,        16'd9,     16'h0001, 1'b1, '{ST_ID_NOT_FOUND, 16'd0, 16'd9, 1'b0}}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [ADDR_W-1:0] cfg_data_i;

  ffha_req_if req_if ();
  ffha_rsp_if rsp_if ();

  first_fit_hole_allocator_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // allocator model state
  logic [ADDR_W-1:0] limit_reg;
  logic [ADDR_W-1:0] bump_ptr;
  logic [ID_W-1:0]   next_id;
  logic [ID_W-1:0]   last_freed_id;
  live_t             live_blocks [$];
  hole_t             free_holes [$];

  rsp_t pending_results [$];
  int   mismatches;
  int   beats_sent;
  bit   quiet;
  bit   hold_off_go;
  int   tx_window;
  bit   tx_calm;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  function automatic rsp_t allocator_outcome(op_e op, logic [SIZE_W-1:0] sz,
                                             logic [ID_W-1:0] id);
    rsp_t  r;
    live_t e;
    int    k;
    r = ANY;
    k = -1;
    if (op == OP_ALLOC) begin
      if (live_blocks.size() >= LIVE_ENTRIES) begin
        r.status = ST_TABLE_FULL;
        return r;
      end
      foreach (free_holes[i]) begin
        if (k < 0 && free_holes[i].size >= sz) k = i;
      end
      if (k >= 0) begin
        e.addr = free_holes[k].addr;
        e.size = free_holes[k].size;
        free_holes.delete(k);
        r.reused_hole = 1'b1;
      end else if (int'(bump_ptr) + int'(sz) <= int'(limit_reg)) begin
        e.addr = bump_ptr;
        e.size = sz;
        bump_ptr = bump_ptr + ADDR_W'(sz);
      end else begin
        r.status = ST_NO_SPACE;
        return r;
      end
      e.id = next_id;
      live_blocks.push_back(e);
      r.block_address = e.addr;
      r.block_id = next_id;
      next_id = next_id + 1'b1;
    end else begin
      r.block_id = id;
      foreach (live_blocks[i]) begin
        if (k < 0 && live_blocks[i].id == id) k = i;
      end
      if (k < 0) begin
        r.status = ST_ID_NOT_FOUND;
        return r;
      end
      e = live_blocks[k];
      live_blocks.delete(k);
      last_freed_id = id;
      r.block_address = e.addr;
      if (free_holes.size() >= HOLE_ENTRIES) r.status = ST_HOLE_DROPPED;
      else free_holes.push_back(hole_t'{addr: e.addr, size: e.size});
    end
    return r;
  endfunction

  task automatic send_beat(op_e op, logic [SIZE_W-1:0] sz, logic [ID_W-1:0] id,
                           logic typed, rsp_t want);
    int   gap;
    rsp_t got;
    if (tx_window == 0) begin
      tx_window = $urandom_range(10, 60);
      tx_calm = ($urandom_range(0, 2) == 0);
    end
    tx_window--;
    gap = (!quiet && !tx_calm && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.operation    <= op;
    req_if.request_size <= sz;
    req_if.free_id      <= id;
    do @(posedge clk_i); while (!req_if.ready);
    got = allocator_outcome(op, sz, id);
    pending_results.push_back(typed ? want : got);
    beats_sent++;
    if (beats_sent >= QUIET_FROM) quiet = 1'b1;
  endtask

  task automatic issue_alloc(logic [SIZE_W-1:0] sz);
    send_beat(OP_ALLOC, sz, ID_W'($urandom), 1'b0, ANY);
  endtask

  task automatic issue_free(logic [ID_W-1:0] id);
    send_beat(OP_FREE, SIZE_W'($urandom), id, 1'b0, ANY);
  endtask

  function automatic logic [SIZE_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return SIZE_W'($urandom_range(1, 24));
    if (r == 9) return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
    return SIZE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [ID_W-1:0] pick_free_id();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7 && live_blocks.size() > 0)
      return live_blocks[$urandom_range(0, live_blocks.size() - 1)].id;
    if (r < 9) return last_freed_id;
    return ID_W'($urandom);
  endfunction

  // wait for the block to go idle
  task automatic settle();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (IDLE_GUARD) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [ADDR_W-1:0] value);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    limit_reg = value;
  endtask

  task automatic run_until(int target);
    int pick;
    int n;
    while (beats_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        repeat (LIVE_ENTRIES + 1) issue_alloc(rand_size());
      end else if (pick < 4) begin
        n = live_blocks.size();
        repeat (n) issue_free(live_blocks[$urandom_range(0, live_blocks.size() - 1)].id);
        if ($urandom_range(0, 1) == 0) issue_free(last_freed_id);
      end else begin
        repeat ($urandom_range(8, 20)) begin
          if ($urandom_range(0, 99) < 55) issue_alloc(rand_size());
          else issue_free(pick_free_id());
        end
      end
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int rx_window;
    bit rx_calm;
    rx_window = 0;
    rx_calm = 1'b0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rx_window == 0) begin
        rx_window = $urandom_range(20, 100);
        rx_calm = ($urandom_range(0, 2) == 0);
      end
      rx_window--;
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!quiet && !rx_calm && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d id %0d",
               rsp_if.status, rsp_if.block_id);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, rsp_if.status);
          mismatches++;
        end
        if (rsp_if.block_address !== want.block_address) begin
          $error("block_address: expected %0d actual %0d",
                 want.block_address, rsp_if.block_address);
          mismatches++;
        end
        if (rsp_if.block_id !== want.block_id) begin
          $error("block_id: expected %0d actual %0d", want.block_id, rsp_if.block_id);
          mismatches++;
        end
        if (rsp_if.reused_hole !== want.reused_hole) begin
          $error("reused_hole: expected %0d actual %0d",
                 want.reused_hole, rsp_if.reused_hole);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int lim;
    int guard;
    mismatches = 0;
    beats_sent = 0;
    quiet = 1'b0;
    hold_off_go = 1'b0;
    tx_window = 0;
    tx_calm = 1'b0;
    limit_reg = HEAP_LIMIT_RESET;
    bump_ptr = '0;
    next_id = ID_W'(1);
    last_freed_id = '0;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_data_i          <= '0;
    req_if.valid        <= 1'b0;
    req_if.operation    <= OP_ALLOC;
    req_if.request_size <= '0;
    req_if.free_id      <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (SCRIPT[i]) begin
      case (SCRIPT[i].kind)
        K_ALLOC: begin
          send_beat(OP_ALLOC, SCRIPT[i].arg[SIZE_W-1:0], SCRIPT[i].noise,
                    SCRIPT[i].typed, SCRIPT[i].want);
        end
        K_FREE: begin
          send_beat(OP_FREE, SCRIPT[i].noise[SIZE_W-1:0], SCRIPT[i].arg,
                    SCRIPT[i].typed, SCRIPT[i].want);
        end
        K_FREE_OLDEST: begin
          send_beat(OP_FREE, SCRIPT[i].noise[SIZE_W-1:0], live_blocks[0].id,
                    SCRIPT[i].typed, SCRIPT[i].want);
        end
        K_FREE_NEWEST: begin
          send_beat(OP_FREE, SCRIPT[i].noise[SIZE_W-1:0], live_blocks[$].id,
                    SCRIPT[i].typed, SCRIPT[i].want);
        end
        default: begin
          write_limit(SCRIPT[i].arg);
        end
      endcase
    end

    run_until(120);
    hold_off_go = 1'b1;
    run_until(220);

    write_limit(ADDR_W'($urandom_range(1, 65535)));
    run_until(300);
    settle();
    run_until(390);

    lim = int'(bump_ptr) + $urandom_range(0, 700);
    if (lim > 65535) lim = 65535;
    write_limit(ADDR_W'(lim));
    run_until(540);

    write_limit(ADDR_W'($urandom_range(int'(bump_ptr), 65535)));
    run_until(END_TARGET);

    req_if.valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (IDLE_GUARD) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> first_fit_hole_allocator_top.f
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_if.sv
hw/rtl/ffha_ram.sv
hw/rtl/first_fit_hole_allocator_top.sv
hw/rtl/ffha_checker.sv
dv/tb.sv
